// ===== hw/rtl/rspe_pkg.sv =====
// Shared types, constants and GF(256) helpers for the Reed-Solomon parity encoder.
// No dependencies; every other file in hw/rtl imports this package.
package rspe_pkg;

  localparam int MAX_PARITY_DEF = 30;
  localparam int ECC_W          = 5;
  localparam logic [ECC_W-1:0] ECC_RESET = 5'd10;
  localparam logic [7:0] FIELD_POLY_LO = 8'h1D;  // x^8 + x^4 + x^3 + x^2 + 1, top bit implied

  // Register map, by word index
  localparam logic REG_ECC_COUNT = 1'b0;
  localparam int   CFG_ADDR_W    = 3;
  localparam int   CFG_DATA_W    = 32;

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] parity_byte;
    logic       parity_last;
  } out_beat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rspe_qstat_t;

  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY_LO : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = gf_xtime(x);
    end
    gf_mul = acc;
  endfunction

endpackage

// ===== hw/rtl/rspe_gen.sv =====
// Generator polynomial builder: one root factor (x + alpha^i) multiplied in per cycle.
// Depends on rspe_pkg.
module rspe_gen #(
  parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF,
  parameter int NW = $clog2(MAX_PARITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,     // restart with the current count
  input  logic [NW-1:0]               eff_n,
  output logic                        busy,
  output logic [MAX_PARITY-1:0][7:0]  coeffs
);
  import rspe_pkg::*;

  logic [MAX_PARITY-1:0][7:0] poly_r, poly_nxt;
  logic [7:0]                 root_r;
  logic [NW-1:0]              iter_r;
  logic                       busy_r;

  // Multiply the running product by (x + root); entries above the degree stay zero.
  always_comb begin
    for (int k = 0; k < MAX_PARITY; k++) begin
      if (k == 0) begin
        poly_nxt[k] = gf_mul(poly_r[k], root_r);
      end else begin
        poly_nxt[k] = poly_r[k-1] ^ gf_mul(poly_r[k], root_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      busy_r <= 1'b1;
      iter_r <= '0;
      root_r <= 8'h01;
      poly_r <= (MAX_PARITY*8)'(1);
    end else if (busy_r) begin
      poly_r <= poly_nxt;
      root_r <= gf_xtime(root_r);
      iter_r <= iter_r + NW'(1);
      if (iter_r + NW'(1) == eff_n) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy   = busy_r;
  assign coeffs = poly_r;

endmodule

// ===== hw/rtl/rspe_front.sv =====
// Front end: advances the parity LFSR one byte per cycle while in_stall is low.
// Depends on rspe_pkg; hands finished parity sets to rspe_queue.
module rspe_front #(
  parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF,
  parameter int NW = $clog2(MAX_PARITY + 1),
  parameter int CW = $clog2(MAX_PARITY)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rspe_pkg::in_beat_t          in_data,
  input  logic [MAX_PARITY-1:0][7:0]  coeffs,
  input  logic [NW-1:0]               eff_n,
  input  logic                        gen_busy,
  input  logic                        clear,
  input  rspe_pkg::rspe_qstat_t       qstat,
  output logic                        push,
  output logic [MAX_PARITY-1:0][7:0]  push_set
);
  import rspe_pkg::*;

  // Register m holds the coefficient of x^m; the top one in use is m = n-1.
  logic [MAX_PARITY-1:0][7:0] lfsr_r, lfsr_nxt;
  logic [CW-1:0]              top_sel;
  logic [7:0]                 feedback;
  logic                       accept;

  assign top_sel  = CW'(eff_n - NW'(1));
  assign feedback = in_data.data_byte ^ lfsr_r[top_sel];

  always_comb begin
    for (int m = 0; m < MAX_PARITY; m++) begin
      if (m == 0) begin
        lfsr_nxt[m] = gf_mul(feedback, coeffs[m]);
      end else begin
        lfsr_nxt[m] = lfsr_r[m-1] ^ gf_mul(feedback, coeffs[m]);
      end
    end
  end

  assign in_stall = gen_busy || clear || qstat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && in_data.block_end;
  assign push_set = lfsr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      lfsr_r <= '0;
    end else if (accept) begin
      lfsr_r <= in_data.block_end ? '0 : lfsr_nxt;
    end
  end

endmodule

// ===== hw/rtl/rspe_queue.sv =====
// Two-entry queue of finished parity sets between front and back ends.
// Depends on rspe_pkg.
module rspe_queue #(
  parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [MAX_PARITY-1:0][7:0]  push_set,
  input  logic                        pop,
  output logic [MAX_PARITY-1:0][7:0]  head_set,
  output rspe_pkg::rspe_qstat_t       qstat
);
  import rspe_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CNTW = $clog2(Q_DEPTH + 1);

  logic [MAX_PARITY-1:0][7:0] mem [Q_DEPTH];
  logic [PW-1:0]              wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]            count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNTW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNTW'(1);
      end
    end
  end

  assign head_set    = mem[rd_ptr_r];
  assign qstat.full  = (count_r == CNTW'(Q_DEPTH));
  assign qstat.empty = (count_r == '0);

endmodule

// ===== hw/rtl/rspe_back.sv =====
// Back end: walks the head parity set highest register first into the output register.
// Depends on rspe_pkg; reads from rspe_queue.
module rspe_back #(
  parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF,
  parameter int NW = $clog2(MAX_PARITY + 1),
  parameter int CW = $clog2(MAX_PARITY)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [MAX_PARITY-1:0][7:0]  head_set,
  input  rspe_pkg::rspe_qstat_t       qstat,
  input  logic [NW-1:0]               eff_n,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rspe_pkg::out_beat_t         out_data
);
  import rspe_pkg::*;

  logic [CW-1:0] idx_r;
  logic [CW-1:0] sel;
  logic          is_last;
  logic          load_ok;
  logic          emit;
  logic          out_valid_r;
  out_beat_t     out_data_r;

  assign sel     = CW'(eff_n - NW'(1) - NW'(idx_r));
  assign is_last = (NW'(idx_r) == eff_n - NW'(1));
  assign load_ok = !out_valid_r || !out_stall;
  assign emit    = load_ok && !qstat.empty;
  assign pop     = emit && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load_ok) begin
      out_valid_r <= !qstat.empty;
      if (emit) begin
        idx_r <= is_last ? '0 : idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.parity_byte <= head_set[sel];
      out_data_r.parity_last <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/reed_solomon_parity_encoder_core.sv =====
// Top level of the systematic Reed-Solomon parity encoder over GF(256), poly 0x11D.
// Depends on rspe_pkg, rspe_gen, rspe_front, rspe_queue and rspe_back.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one message byte per beat;
//   block_end marks the last byte of a block. Output channel (out_valid /
//   out_stall / out_data): after a block_end beat, n parity beats come out,
//   highest-order register first, parity_last set on the final one.
//   n is ecc_count clamped to 1 .. MAX_PARITY; ecc_count sits at byte address 0
//   of the APB port. Write it only while the block is idle; the write clears
//   the parity registers and drops a partly absorbed block.
// Timing:
//   A byte is taken every cycle while in_stall is low. With the back end idle, a
//   block_end beat's parity set is queued, then the back end registers the first
//   parity beat, then one beat per cycle while out_stall is low. The queue holds
//   two sets, so a stalled receiver only backs up into in_stall once both are taken.
// Reset and configuration:
//   After reset (n = 10) and after each ecc_count write, the generator polynomial
//   is rebuilt one root per cycle; in_stall stays high until it is done. A stalled
//   output beat holds its payload.
module reed_solomon_parity_encoder_core #(
  parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  rspe_pkg::in_beat_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output rspe_pkg::out_beat_t                   out_data,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rspe_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [rspe_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [rspe_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);
  import rspe_pkg::*;

  localparam int NW = $clog2(MAX_PARITY + 1);
  localparam int CW = $clog2(MAX_PARITY);
  localparam int EW = (NW > ECC_W) ? NW : ECC_W;

  logic [ECC_W-1:0]           ecc_count_r;
  logic                       cfg_wr;
  logic [EW-1:0]              ecc_ext;
  logic [NW-1:0]              eff_n;
  logic                       gen_busy;
  logic [MAX_PARITY-1:0][7:0] coeffs;
  logic                       push;
  logic                       pop;
  logic [MAX_PARITY-1:0][7:0] push_set;
  logic [MAX_PARITY-1:0][7:0] head_set;
  rspe_qstat_t                qstat;

  // APB: zero-wait, write in the access phase at word index 0.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ECC_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecc_count_r <= ECC_RESET;
    end else if (cfg_wr) begin
      ecc_count_r <= pwdata[ECC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ECC_COUNT) begin
      prdata = CFG_DATA_W'(ecc_count_r);
    end
  end

  // Clamp the count: zero acts as one, anything past the storage acts as the top.
  assign ecc_ext = EW'(ecc_count_r);
  always_comb begin
    if (ecc_ext == '0) begin
      eff_n = NW'(1);
    end else if (ecc_ext > EW'(MAX_PARITY)) begin
      eff_n = NW'(MAX_PARITY);
    end else begin
      eff_n = NW'(ecc_ext);
    end
  end

  rspe_gen #(.MAX_PARITY(MAX_PARITY), .NW(NW)) u_gen (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cfg_wr),
    .eff_n  (eff_n),
    .busy   (gen_busy),
    .coeffs (coeffs)
  );

  rspe_front #(.MAX_PARITY(MAX_PARITY), .NW(NW), .CW(CW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .coeffs   (coeffs),
    .eff_n    (eff_n),
    .gen_busy (gen_busy),
    .clear    (cfg_wr),
    .qstat    (qstat),
    .push     (push),
    .push_set (push_set)
  );

  rspe_queue #(.MAX_PARITY(MAX_PARITY)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_set (push_set),
    .pop      (pop),
    .head_set (head_set),
    .qstat    (qstat)
  );

  rspe_back #(.MAX_PARITY(MAX_PARITY), .NW(NW), .CW(CW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_set  (head_set),
    .qstat     (qstat),
    .eff_n     (eff_n),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // No byte may enter the LFSR while the generator is still being rebuilt.
  a_no_accept_while_building: assert property (@(posedge clk) disable iff (!rst_n)
    gen_busy |-> !(in_valid && !in_stall))
    else $error("input beat taken during generator rebuild");

  // A finished parity set never lands on a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("parity set pushed into full queue");

  // The back end only retires a set that is there, and does so on the last beat.
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid && out_data.parity_last))
    else $error("queue pop without a final parity beat");

endmodule
